/* sv/kts_pkg.sv */
// Shared constants and control structs for the key/tag quicksort block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package kts_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned TAG_BITS_DEF  = 16;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned TAG_IO_W      = 16;
  localparam int unsigned DATA_W        = ((KEY_W + TAG_IO_W + 7) / 8) * 8;
  localparam int unsigned STACK_SLOTS   = 64;

  // Range stack request from the sequencer.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
  } stk_sts_t;

  // Result register load request from the sequencer.
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } out_ctl_t;

endpackage

`default_nettype wire

/* sv/kts_pair_store.sv */
// Key/tag pair memory: one write port, one read port, registered read data.
// Uses kts_pkg for the key width.
`default_nettype none

module kts_pair_store #(
  parameter int unsigned DEPTH    = kts_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TAG_BITS = kts_pkg::TAG_BITS_DEF,
  localparam int unsigned IDX_W   = $clog2(DEPTH)
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire [IDX_W-1:0]             waddr_i,
  input  wire [kts_pkg::KEY_W-1:0]    wkey_i,
  input  wire [TAG_BITS-1:0]          wtag_i,
  input  wire                         re_i,
  input  wire [IDX_W-1:0]             raddr_i,
  output logic [kts_pkg::KEY_W-1:0]   rkey_o,
  output logic [TAG_BITS-1:0]         rtag_o
);

  logic [kts_pkg::KEY_W+TAG_BITS-1:0] pair_mem [DEPTH];
  logic [kts_pkg::KEY_W+TAG_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pair_mem[waddr_i] <= {wtag_i, wkey_i};
    end
    if (re_i) begin
      rd_q <= pair_mem[raddr_i];
    end
  end

  assign rkey_o = rd_q[kts_pkg::KEY_W-1:0];
  assign rtag_o = rd_q[kts_pkg::KEY_W+TAG_BITS-1:kts_pkg::KEY_W];

endmodule

`default_nettype wire

/* sv/kts_range_stack.sv */
// Stack of pending index ranges held in a synchronous memory with a depth pointer.
// Uses kts_pkg for the slot count and the request/status structs.
`default_nettype none

module kts_range_stack #(
  parameter int unsigned ENTRY_W = 12
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  kts_pkg::stk_ctl_t      ctl_i,
  input  wire [ENTRY_W-1:0]      push_entry_i,
  output logic [ENTRY_W-1:0]     pop_entry_o,
  output kts_pkg::stk_sts_t      sts_o
);

  localparam int unsigned SLOTS  = kts_pkg::STACK_SLOTS;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned SP_W   = $clog2(SLOTS + 1);

  logic [ENTRY_W-1:0] stack_mem [SLOTS];
  logic [ENTRY_W-1:0] rd_q;
  logic [SP_W-1:0]    sp_q, sp_d, sp_m1;
  logic               can_push;

  assign sp_m1    = sp_q - SP_W'(1);
  assign can_push = ctl_i.push && (sp_q < SP_W'(SLOTS));

  always_comb begin
    sp_d = sp_q;
    if (can_push) begin
      sp_d = sp_q + SP_W'(1);
    end else if (ctl_i.pop && (sp_q != '0)) begin
      sp_d = sp_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    // drop a push when every slot is taken
    if (can_push) begin
      stack_mem[sp_q[SLOT_W-1:0]] <= push_entry_i;
    end
    if (ctl_i.pop) begin
      rd_q <= stack_mem[sp_m1[SLOT_W-1:0]];
    end
  end

  assign pop_entry_o = rd_q;
  assign sts_o.empty = (sp_q == '0);

endmodule

`default_nettype wire

/* sv/kts_ctrl.sv */
// Sequencer: loads a batch, runs Hoare partitioning over the pair store, emits results.
// Drives kts_pair_store and kts_range_stack; uses kts_pkg structs.
`default_nettype none

module kts_ctrl #(
  parameter int unsigned MAX_ITEMS = kts_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TAG_BITS  = kts_pkg::TAG_BITS_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_ITEMS),
  localparam int unsigned CNT_W    = $clog2(MAX_ITEMS + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [kts_pkg::KEY_W-1:0]     in_key_i,
  input  wire [TAG_BITS-1:0]           in_tag_i,
  input  wire                          in_last_i,
  input  wire                          out_free_i,
  output kts_pkg::out_ctl_t            out_ctl_o,
  output logic                         st_we_o,
  output logic [IDX_W-1:0]             st_waddr_o,
  output logic [kts_pkg::KEY_W-1:0]    st_wkey_o,
  output logic [TAG_BITS-1:0]          st_wtag_o,
  output logic                         st_re_o,
  output logic [IDX_W-1:0]             st_raddr_o,
  input  wire [kts_pkg::KEY_W-1:0]     st_rkey_i,
  input  wire [TAG_BITS-1:0]           st_rtag_i,
  output kts_pkg::stk_ctl_t            stk_ctl_o,
  output logic [2*IDX_W-1:0]           stk_entry_o,
  input  wire [2*IDX_W-1:0]            stk_entry_i,
  input  kts_pkg::stk_sts_t            stk_sts_i
);

  localparam int unsigned SW = IDX_W + 2;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_RANGE = 4'd3;
  localparam logic [3:0] S_PIVOT = 4'd4;
  localparam logic [3:0] S_IRD   = 4'd5;
  localparam logic [3:0] S_ICK   = 4'd6;
  localparam logic [3:0] S_JRD   = 4'd7;
  localparam logic [3:0] S_JCK   = 4'd8;
  localparam logic [3:0] S_DEC   = 4'd9;
  localparam logic [3:0] S_SWA   = 4'd10;
  localparam logic [3:0] S_SWB   = 4'd11;
  localparam logic [3:0] S_PSH1  = 4'd12;
  localparam logic [3:0] S_PSH2  = 4'd13;
  localparam logic [3:0] S_ORD   = 4'd14;
  localparam logic [3:0] S_OLD   = 4'd15;

  logic [3:0]                 state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic [IDX_W-1:0]           lo_q, lo_d, hi_q, hi_d, r_q, r_d;
  logic signed [SW-1:0]       i_q, i_d, j_q, j_d;
  logic signed [kts_pkg::KEY_W-1:0] pivot_q, pivot_d;
  logic [kts_pkg::KEY_W-1:0]  ri_key_q, ri_key_d, rj_key_q, rj_key_d;
  logic [TAG_BITS-1:0]        ri_tag_q, ri_tag_d, rj_tag_q, rj_tag_d;

  logic [IDX_W-1:0]           pop_lo, pop_hi;
  logic [IDX_W:0]             mid_sum;
  logic signed [SW-1:0]       lo_s, hi_s, i_inc, j_dec;
  logic signed [kts_pkg::KEY_W-1:0] rkey_s;
  logic                       accept, store_it;
  logic [CNT_W-1:0]           n_next, n_m1;

  assign pop_lo  = stk_entry_i[IDX_W-1:0];
  assign pop_hi  = stk_entry_i[2*IDX_W-1:IDX_W];
  assign mid_sum = {1'b0, pop_lo} + {1'b0, pop_hi};
  assign lo_s    = $signed({2'b00, lo_q});
  assign hi_s    = $signed({2'b00, hi_q});
  assign i_inc   = i_q + SW'(1);
  assign j_dec   = j_q - SW'(1);
  assign rkey_s  = $signed(st_rkey_i);
  assign accept  = in_valid_i && (state_q == S_LOAD);
  assign store_it = cnt_q < CNT_W'(MAX_ITEMS);
  assign n_next  = store_it ? cnt_q + CNT_W'(1) : cnt_q;
  assign n_m1    = cnt_q - CNT_W'(1);
  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    r_d      = r_q;
    i_d      = i_q;
    j_d      = j_q;
    pivot_d  = pivot_q;
    ri_key_d = ri_key_q;
    ri_tag_d = ri_tag_q;
    rj_key_d = rj_key_q;
    rj_tag_d = rj_tag_q;

    st_we_o     = 1'b0;
    st_waddr_o  = cnt_q[IDX_W-1:0];
    st_wkey_o   = in_key_i;
    st_wtag_o   = in_tag_i;
    st_re_o     = 1'b0;
    st_raddr_o  = i_q[IDX_W-1:0];
    stk_ctl_o   = '0;
    stk_entry_o = {hi_q, i_q[IDX_W-1:0]};
    out_ctl_o   = '0;

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (store_it) begin
            st_we_o = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            r_d     = '0;
            state_d = (n_next >= CNT_W'(2)) ? S_INIT : S_ORD;
          end
        end
      end
      S_INIT: begin
        stk_ctl_o.push = 1'b1;
        stk_entry_o    = {n_m1[IDX_W-1:0], IDX_W'(0)};
        state_d        = S_POP;
      end
      S_POP: begin
        if (stk_sts_i.empty) begin
          r_d     = '0;
          state_d = S_ORD;
        end else begin
          stk_ctl_o.pop = 1'b1;
          state_d       = S_RANGE;
        end
      end
      S_RANGE: begin
        if ((CNT_W'(pop_hi) >= cnt_q) || (pop_lo > pop_hi)) begin
          state_d = S_POP;
        end else begin
          st_re_o    = 1'b1;
          st_raddr_o = mid_sum[IDX_W:1];
          lo_d       = pop_lo;
          hi_d       = pop_hi;
          i_d        = $signed({2'b00, pop_lo});
          j_d        = $signed({2'b00, pop_hi});
          state_d    = S_PIVOT;
        end
      end
      S_PIVOT: begin
        pivot_d = rkey_s;
        state_d = S_IRD;
      end
      S_IRD: begin
        if (i_q <= hi_s) begin
          st_re_o    = 1'b1;
          st_raddr_o = i_q[IDX_W-1:0];
          state_d    = S_ICK;
        end else begin
          state_d = S_JRD;
        end
      end
      S_ICK: begin
        // advance i and fetch the next entry in the same cycle
        if (rkey_s < pivot_q) begin
          i_d = i_inc;
          if (i_inc <= hi_s) begin
            st_re_o    = 1'b1;
            st_raddr_o = i_inc[IDX_W-1:0];
          end else begin
            state_d = S_JRD;
          end
        end else begin
          ri_key_d = st_rkey_i;
          ri_tag_d = st_rtag_i;
          state_d  = S_JRD;
        end
      end
      S_JRD: begin
        if (j_q >= lo_s) begin
          st_re_o    = 1'b1;
          st_raddr_o = j_q[IDX_W-1:0];
          state_d    = S_JCK;
        end else begin
          state_d = S_DEC;
        end
      end
      S_JCK: begin
        if (rkey_s > pivot_q) begin
          j_d = j_dec;
          if (j_dec >= lo_s) begin
            st_re_o    = 1'b1;
            st_raddr_o = j_dec[IDX_W-1:0];
          end else begin
            state_d = S_DEC;
          end
        end else begin
          rj_key_d = st_rkey_i;
          rj_tag_d = st_rtag_i;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d = (i_q <= j_q) ? S_SWA : S_PSH1;
      end
      S_SWA: begin
        st_we_o    = 1'b1;
        st_waddr_o = i_q[IDX_W-1:0];
        st_wkey_o  = rj_key_q;
        st_wtag_o  = rj_tag_q;
        state_d    = S_SWB;
      end
      S_SWB: begin
        st_we_o    = 1'b1;
        st_waddr_o = j_q[IDX_W-1:0];
        st_wkey_o  = ri_key_q;
        st_wtag_o  = ri_tag_q;
        i_d        = i_inc;
        j_d        = j_dec;
        state_d    = (i_inc <= j_dec) ? S_IRD : S_PSH1;
      end
      S_PSH1: begin
        if (i_q < hi_s) begin
          stk_ctl_o.push = 1'b1;
          stk_entry_o    = {hi_q, i_q[IDX_W-1:0]};
        end
        state_d = S_PSH2;
      end
      S_PSH2: begin
        if (lo_s < j_q) begin
          stk_ctl_o.push = 1'b1;
          stk_entry_o    = {j_q[IDX_W-1:0], lo_q};
        end
        state_d = S_POP;
      end
      S_ORD: begin
        // hold until the result register can take a new entry
        if (out_free_i) begin
          st_re_o    = 1'b1;
          st_raddr_o = r_q;
          state_d    = S_OLD;
        end
      end
      S_OLD: begin
        out_ctl_o.load = 1'b1;
        out_ctl_o.ovf  = ovf_q;
        out_ctl_o.last = (CNT_W'(r_q) == n_m1);
        r_d            = r_q + IDX_W'(1);
        if (CNT_W'(r_q) == n_m1) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end else begin
          state_d = S_ORD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    r_q      <= r_d;
    i_q      <= i_d;
    j_q      <= j_d;
    pivot_q  <= pivot_d;
    ri_key_q <= ri_key_d;
    ri_tag_q <= ri_tag_d;
    rj_key_q <= rj_key_d;
    rj_tag_q <= rj_tag_d;
  end

endmodule

`default_nettype wire

/* sv/key_tag_quicksort.sv */
// Channel   Dir  Width  Contents
// s_axis    in   48     tdata: key[31:0], tag[47:32]; tlast closes the batch
// m_axis    out  48     tdata: sorted_key[31:0], sorted_tag[47:32]; tlast final, tuser ovf
//
// Loading accepts one request per cycle. After the last request the pairs are sorted in
// place, one popped range at a time: a pivot read, the i and j key scans, then swaps of two
// writes each, with every read going through the single read port of the pair memory.
// Results then leave through the output register; each is read only once that register is free.
// Reset clears the sequencer, the batch count and the stack pointer; memories keep data.
// A stalled output holds its request; input is taken only while a batch is loading.
// Top level of the key/tag quicksort; depends on kts_pkg, kts_ctrl, kts_pair_store,
// and kts_range_stack.
`default_nettype none

module key_tag_quicksort #(
  parameter int unsigned MAX_ITEMS = kts_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TAG_BITS  = kts_pkg::TAG_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire [kts_pkg::DATA_W-1:0]   s_axis_tdata,   // key[31:0], tag[47:32]
  input  wire                         s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [kts_pkg::DATA_W-1:0]  m_axis_tdata,   // sorted_key[31:0], sorted_tag[47:32]
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser    // overflow
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned KW    = kts_pkg::KEY_W;
  localparam int unsigned TW    = kts_pkg::TAG_IO_W;

  logic [TAG_BITS+TW-1:0]     in_tag_ext, out_tag_ext;
  logic [TAG_BITS-1:0]        in_tag;
  kts_pkg::out_ctl_t          out_ctl;
  logic                       st_we, st_re;
  logic [IDX_W-1:0]           st_waddr, st_raddr;
  logic [KW-1:0]              st_wkey, st_rkey;
  logic [TAG_BITS-1:0]        st_wtag, st_rtag;
  kts_pkg::stk_ctl_t          stk_ctl;
  kts_pkg::stk_sts_t          stk_sts;
  logic [2*IDX_W-1:0]         stk_push, stk_pop;

  logic                       m_valid_q;
  logic [KW-1:0]              m_key_q;
  logic [TW-1:0]              m_tag_q;
  logic                       m_last_q, m_user_q;

  // keep the low TAG_BITS of the tag
  assign in_tag_ext  = {TAG_BITS'(0), s_axis_tdata[KW+TW-1:KW]};
  assign in_tag      = in_tag_ext[TAG_BITS-1:0];
  assign out_tag_ext = {TW'(0), st_rtag};

  kts_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .TAG_BITS  (TAG_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_key_i    (s_axis_tdata[KW-1:0]),
    .in_tag_i    (in_tag),
    .in_last_i   (s_axis_tlast),
    .out_free_i  (!m_valid_q || m_axis_tready),
    .out_ctl_o   (out_ctl),
    .st_we_o     (st_we),
    .st_waddr_o  (st_waddr),
    .st_wkey_o   (st_wkey),
    .st_wtag_o   (st_wtag),
    .st_re_o     (st_re),
    .st_raddr_o  (st_raddr),
    .st_rkey_i   (st_rkey),
    .st_rtag_i   (st_rtag),
    .stk_ctl_o   (stk_ctl),
    .stk_entry_o (stk_push),
    .stk_entry_i (stk_pop),
    .stk_sts_i   (stk_sts)
  );

  kts_pair_store #(
    .DEPTH    (MAX_ITEMS),
    .TAG_BITS (TAG_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wkey_i  (st_wkey),
    .wtag_i  (st_wtag),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rkey_o  (st_rkey),
    .rtag_o  (st_rtag)
  );

  kts_range_stack #(
    .ENTRY_W (2 * IDX_W)
  ) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (stk_ctl),
    .push_entry_i (stk_push),
    .pop_entry_o  (stk_pop),
    .sts_o        (stk_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ctl.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctl.load) begin
      m_key_q  <= st_rkey;
      m_tag_q  <= out_tag_ext[TW-1:0];
      m_last_q <= out_ctl.last;
      m_user_q <= out_ctl.ovf;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(kts_pkg::DATA_W - KW - TW){1'b0}}, m_tag_q, m_key_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

/* sv/kts_checker.sv */
// Port-level checks for key_tag_quicksort, attached by the bind at the end of this file.
// Depends on kts_pkg for the data width.
`default_nettype none

module kts_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        s_axis_tvalid,
  input wire                        s_axis_tready,
  input wire                        s_axis_tlast,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [kts_pkg::DATA_W-1:0]  m_axis_tdata,
  input wire                        m_axis_tlast,
  input wire                        m_axis_tuser
);

  logic                             out_acc, in_acc;
  logic                             mid_q;
  logic signed [kts_pkg::KEY_W-1:0] prev_key_q;
  logic                             prev_user_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // track the previous result of the running batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      prev_key_q  <= '0;
      prev_user_q <= 1'b0;
    end else if (out_acc) begin
      mid_q       <= !m_axis_tlast;
      prev_key_q  <= $signed(m_axis_tdata[kts_pkg::KEY_W-1:0]);
      prev_user_q <= m_axis_tuser;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_no_load_mid_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready while results are still pending");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> $signed(m_axis_tdata[kts_pkg::KEY_W-1:0]) >= prev_key_q)
    else $error("results not in ascending key order");

  a_flag_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> m_axis_tuser == prev_user_q)
    else $error("overflow flag changed within a batch");

  a_sort_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after the batch closed");

endmodule

bind key_tag_quicksort kts_checker u_kts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
